>>> hdl/rau_pkg.sv
// ============================================================================
// Rational arithmetic unit package
// Shared types and constants for the fraction arithmetic block.
// ============================================================================
`default_nettype none

package rau_pkg;

    localparam int unsigned WIDE_W = 64;

    typedef enum logic [2:0] {
        KIND_ADD = 3'd0,
        KIND_MUL = 3'd1,
        KIND_DIV = 3'd2,
        KIND_EQ  = 3'd3,
        KIND_RED = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    // Commands from the sequencer to the shared divider.
    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] dividend;
        logic [WIDE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] quotient;
        logic [WIDE_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> hdl/rau_divider.sv
// ============================================================================
// Rational arithmetic unit divider
// Radix-2 restoring signed divider with truncating quotient and remainder.
// ============================================================================
`default_nettype none

module rau_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t      rsp
);
    import rau_pkg::*;

    localparam int unsigned CNT_W = $clog2(WIDE_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WIDE_W-1:0] rem_reg;
    logic [WIDE_W-1:0] quo_reg;
    logic [WIDE_W-1:0] dvs_reg;
    logic              qneg_reg;
    logic              rneg_reg;
    logic              done_reg;
    logic [WIDE_W:0]   trial;
    logic [WIDE_W-1:0] shifted;

    always_comb begin
        shifted = {rem_reg[WIDE_W-2:0], quo_reg[WIDE_W-1]};
        trial   = {1'b0, shifted} - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDE_W);
                rem_reg  <= '0;
                quo_reg  <= req.dividend[WIDE_W-1] ? -req.dividend : req.dividend;
                dvs_reg  <= req.divisor[WIDE_W-1] ? -req.divisor : req.divisor;
                qneg_reg <= req.dividend[WIDE_W-1] ^ req.divisor[WIDE_W-1];
                rneg_reg <= req.dividend[WIDE_W-1];
            end else if (busy_reg) begin
                if (!trial[WIDE_W]) begin
                    rem_reg <= trial[WIDE_W-1:0];
                    quo_reg <= {quo_reg[WIDE_W-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[WIDE_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        rsp.done      = done_reg;
        rsp.quotient  = qneg_reg ? -quo_reg : quo_reg;
        rsp.remainder = rneg_reg ? -rem_reg : rem_reg;
    end

endmodule

`default_nettype wire

>>> hdl/rau_sequencer.sv
// ============================================================================
// Rational arithmetic unit sequencer
// Steps one request through products, Euclid and exact divisions.
// ============================================================================
`default_nettype none

module rau_sequencer #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [2:0]         kind,
    input  wire logic [31:0]        num_a,
    input  wire logic [31:0]        den_a,
    input  wire logic [31:0]        num_b,
    input  wire logic [31:0]        den_b,
    output logic                    busy,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [63:0]             result_num,
    output logic [63:0]             result_den,
    output logic                    is_equal,
    output logic                    can_reduce,
    output logic [1:0]              status,
    output rau_pkg::div_req_t       div_req,
    input  wire rau_pkg::div_rsp_t  div_rsp
);
    import rau_pkg::*;

    localparam int unsigned MUL_W = 33;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_DECIDE, S_GCD, S_GCD_WAIT, S_Q1, S_Q1_WAIT,
        S_Q2, S_Q2_WAIT, S_ADD, S_DEN, S_SUM, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        G_ADD, G_RED, G_CHK
    } gmode_t;

    state_t            state_reg;
    gmode_t            gmode_reg;
    logic [2:0]        kind_reg;
    logic [WIDE_W-1:0] na_reg, da_reg, nb_reg, db_reg;
    logic [WIDE_W-1:0] p1_reg, p2_reg;
    logic [WIDE_W-1:0] ga_reg, gb_reg;
    logic [WIDE_W-1:0] q1_reg, q2_reg;
    logic [WIDE_W-1:0] rn_reg, rd_reg;
    logic              eq_reg, cr_reg;
    logic [1:0]        st_reg;
    logic [WIDE_W-1:0] mul_x, mul_y, mul_p;
    logic signed [2*MUL_W-1:0] mul_full;
    logic [WIDE_W-1:0] sum;
    logic              ovf;

    function automatic logic [WIDE_W-1:0] sext(input logic [31:0] v);
        logic [OPERAND_WIDTH-1:0] t;
        t = v[OPERAND_WIDTH-1:0];
        return WIDE_W'($signed(t));
    endfunction

    always_comb begin
        mul_full = $signed(mul_x[MUL_W-1:0]) * $signed(mul_y[MUL_W-1:0]);
        mul_p    = mul_full[WIDE_W-1:0];
        sum      = p1_reg + p2_reg;
        ovf      = (p1_reg[WIDE_W-1] == p2_reg[WIDE_W-1]) &&
                   (sum[WIDE_W-1] != p1_reg[WIDE_W-1]);
    end

    always_comb begin
        mul_x = na_reg;
        mul_y = db_reg;
        unique case (state_reg)
            S_MUL1: begin
                mul_x = na_reg;
                mul_y = (kind_reg == KIND_MUL) ? nb_reg : db_reg;
            end
            S_MUL2: begin
                mul_x = (kind_reg == KIND_DIV) ? da_reg :
                        (kind_reg == KIND_MUL) ? da_reg : nb_reg;
                mul_y = (kind_reg == KIND_DIV) ? nb_reg :
                        (kind_reg == KIND_MUL) ? db_reg : da_reg;
            end
            S_Q2: begin
                mul_x = na_reg;
                mul_y = q1_reg;
            end
            S_ADD: begin
                mul_x = nb_reg;
                mul_y = q2_reg;
            end
            S_DEN: begin
                mul_x = q2_reg;
                mul_y = db_reg;
            end
            default: begin
                mul_x = na_reg;
                mul_y = db_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            div_req.start <= 1'b0;
        end else begin
            div_req.start <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        kind_reg <= kind;
                        na_reg   <= sext(num_a);
                        da_reg   <= sext(den_a);
                        nb_reg   <= sext(num_b);
                        db_reg   <= sext(den_b);
                        rn_reg   <= '0;
                        rd_reg   <= '0;
                        eq_reg   <= 1'b0;
                        cr_reg   <= 1'b0;
                        st_reg   <= ST_OK;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    p1_reg    <= mul_p;
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    p2_reg    <= mul_p;
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    state_reg <= S_GCD;
                    if (kind_reg > KIND_RED) begin
                        state_reg <= S_OUT;
                    end else if (kind_reg == KIND_RED) begin
                        if (da_reg == '0) begin
                            st_reg    <= ST_ZERO;
                            state_reg <= S_OUT;
                        end else begin
                            gmode_reg <= G_RED;
                            ga_reg    <= na_reg;
                            gb_reg    <= da_reg;
                        end
                    end else if (da_reg == '0 || db_reg == '0 ||
                                 (kind_reg == KIND_DIV && nb_reg == '0)) begin
                        st_reg    <= ST_ZERO;
                        state_reg <= S_OUT;
                    end else if (kind_reg == KIND_EQ) begin
                        eq_reg    <= (p1_reg == p2_reg);
                        state_reg <= S_OUT;
                    end else if (kind_reg == KIND_ADD) begin
                        gmode_reg <= G_ADD;
                        ga_reg    <= da_reg;
                        gb_reg    <= db_reg;
                    end else begin
                        rn_reg    <= p1_reg;
                        rd_reg    <= p2_reg;
                        gmode_reg <= G_CHK;
                        ga_reg    <= p1_reg;
                        gb_reg    <= p2_reg;
                    end
                end
                S_GCD: begin
                    if (gb_reg == '0) begin
                        unique case (gmode_reg)
                            G_CHK: begin
                                cr_reg    <= (ga_reg != WIDE_W'(1));
                                state_reg <= S_OUT;
                            end
                            G_RED: begin
                                if (ga_reg == WIDE_W'(1)) begin
                                    rn_reg    <= na_reg;
                                    rd_reg    <= da_reg;
                                    state_reg <= S_OUT;
                                end else begin
                                    cr_reg    <= 1'b1;
                                    state_reg <= S_Q1;
                                end
                            end
                            default: state_reg <= S_Q1;
                        endcase
                    end else if (gb_reg == '1) begin
                        ga_reg <= gb_reg;
                        gb_reg <= '0;
                    end else begin
                        div_req.start    <= 1'b1;
                        div_req.dividend <= ga_reg;
                        div_req.divisor  <= gb_reg;
                        state_reg        <= S_GCD_WAIT;
                    end
                end
                S_GCD_WAIT: begin
                    if (div_rsp.done) begin
                        ga_reg    <= gb_reg;
                        gb_reg    <= div_rsp.remainder;
                        state_reg <= S_GCD;
                    end
                end
                S_Q1: begin
                    div_req.start    <= 1'b1;
                    div_req.dividend <= (gmode_reg == G_RED) ? na_reg : db_reg;
                    div_req.divisor  <= ga_reg;
                    state_reg        <= S_Q1_WAIT;
                end
                S_Q1_WAIT: begin
                    if (div_rsp.done) begin
                        q1_reg    <= div_rsp.quotient;
                        state_reg <= S_Q2;
                    end
                end
                S_Q2: begin
                    p1_reg           <= mul_p;
                    div_req.start    <= 1'b1;
                    div_req.dividend <= da_reg;
                    div_req.divisor  <= ga_reg;
                    state_reg        <= S_Q2_WAIT;
                end
                S_Q2_WAIT: begin
                    if (div_rsp.done) begin
                        q2_reg <= div_rsp.quotient;
                        if (gmode_reg == G_RED) begin
                            rn_reg    <= q1_reg;
                            rd_reg    <= div_rsp.quotient;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_ADD;
                        end
                    end
                end
                S_ADD: begin
                    p2_reg    <= mul_p;
                    state_reg <= S_DEN;
                end
                S_DEN: begin
                    // Denominator is db times da/g.
                    rd_reg    <= mul_p;
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    if (ovf) begin
                        rn_reg    <= '0;
                        rd_reg    <= '0;
                        st_reg    <= ST_OVF;
                        state_reg <= S_OUT;
                    end else begin
                        rn_reg    <= sum;
                        gmode_reg <= G_CHK;
                        ga_reg    <= sum;
                        gb_reg    <= rd_reg;
                        state_reg <= S_GCD;
                    end
                end
                S_OUT: begin
                    if (out_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        busy       = (state_reg != S_IDLE);
        out_valid  = (state_reg == S_OUT);
        result_num = rn_reg;
        result_den = rd_reg;
        is_equal   = eq_reg;
        can_reduce = cr_reg;
        status     = st_reg;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && status != ST_OK |-> result_num == '0 && result_den == '0)
        else $error("nonzero payload on error status");
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == S_GCD_WAIT || state_reg == S_Q1_WAIT ||
                         state_reg == S_Q2_WAIT)
        else $error("divider finished outside a wait state");

endmodule

`default_nettype wire

>>> hdl/rational_arithmetic_unit_top.sv
// ============================================================================
// Rational arithmetic unit
// Fraction add, multiply, divide, equality and reduce with Euclid gcd.
// ============================================================================
// Kinds that need no gcd give their result without the divider; each Euclid
// step and each exact division runs in the shared 64-bit radix-2 divider.
// Throughput: one transaction at a time; s_tready is low until the result is taken.
// Reset: aresetn is synchronous, active low, and returns the sequencer to idle.
`default_nettype none

module rational_arithmetic_unit_top #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // kind[2:0], num_a[34:3], den_a[66:35], num_b[98:67], den_b[130:99], zero fill
    input  wire logic [135:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_num[63:0], result_den[127:64], is_equal[128], can_reduce[129],
    // status[131:130], zero fill
    output logic [135:0]      m_tdata
);
    import rau_pkg::*;

    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic        busy;
    logic [63:0] rn, rd;
    logic        eq, cr;
    logic [1:0]  st;

    rau_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    rau_sequencer #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && s_tready),
        .kind      (s_tdata[2:0]),
        .num_a     (s_tdata[34:3]),
        .den_a     (s_tdata[66:35]),
        .num_b     (s_tdata[98:67]),
        .den_b     (s_tdata[130:99]),
        .busy      (busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result_num(rn),
        .result_den(rd),
        .is_equal  (eq),
        .can_reduce(cr),
        .status    (st),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    assign s_tready = !busy;
    assign m_tdata  = {4'b0, st, cr, eq, rd, rn};

endmodule

`default_nettype wire

>>> verif/rational_arithmetic_unit_top_test.sv
// ============================================================================
// Rational arithmetic unit testbench
// Sends fraction requests of every kind, including unknown kinds, and checks
// each result transaction against a built-in predictor. The requests cover
// extreme operands, zero denominators, add overflow, reducible fractions and
// random traffic. Both sides of the stream stall at random.
// ============================================================================
`default_nettype none

module rational_arithmetic_unit_top_test;
    import rau_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;
    localparam int RANDOM_ITEMS = 780;
    localparam logic signed [31:0] OP_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] OP_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] num_a;
        logic signed [31:0] den_a;
        logic signed [31:0] num_b;
        logic signed [31:0] den_b;
    } request_t;

    typedef struct packed {
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic               is_equal;
        logic               can_reduce;
        status_t            status;
    } fraction_result_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [135:0]   s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [135:0]   m_tdata;

    fraction_result_t pending_results[$];
    int             mismatch_count = 0;
    longint unsigned cycle_count = 0;

    rational_arithmetic_unit_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint trunc_rem(longint a, longint b);
        if (b == -1) begin
            return 0;
        end
        return a % b;
    endfunction

    function automatic longint euclid_gcd(longint a, longint b);
        longint r;
        while (b != 0) begin
            r = trunc_rem(a, b);
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic longint exact_div(longint a, longint g);
        if (g == -1) begin
            return -a;
        end
        return a / g;
    endfunction

    function automatic fraction_result_t predict_fraction(request_t req);
        fraction_result_t res;
        longint na, da, nb, db, g, t1, t2, s;
        res = '0;
        res.status = ST_OK;
        na = req.num_a;
        da = req.den_a;
        nb = req.num_b;
        db = req.den_b;
        if (req.kind > KIND_RED) begin
            return res;
        end
        if (req.kind == KIND_RED) begin
            if (da == 0) begin
                res.status = ST_ZERO;
                return res;
            end
            g = euclid_gcd(na, da);
            if (g != 1) begin
                res.num = exact_div(na, g);
                res.den = exact_div(da, g);
                res.can_reduce = 1'b1;
            end else begin
                res.num = na;
                res.den = da;
            end
            return res;
        end
        if (da == 0 || db == 0 || (req.kind == KIND_DIV && nb == 0)) begin
            res.status = ST_ZERO;
            return res;
        end
        case (req.kind)
            KIND_EQ: begin
                res.is_equal = (na * db == nb * da);
                return res;
            end
            KIND_ADD: begin
                g = euclid_gcd(da, db);
                t1 = na * exact_div(db, g);
                t2 = nb * exact_div(da, g);
                s = t1 + t2;
                if ((t1 < 0) == (t2 < 0) && (s < 0) != (t1 < 0)) begin
                    res.status = ST_OVF;
                    return res;
                end
                res.num = s;
                res.den = exact_div(da * db, g);
            end
            KIND_MUL: begin
                res.num = na * nb;
                res.den = da * db;
            end
            default: begin
                res.num = na * db;
                res.den = da * nb;
            end
        endcase
        res.can_reduce = (euclid_gcd(res.num, res.den) != 1);
        return res;
    endfunction

    // Result checker: one expectation is consumed per accepted transaction.
    always @(posedge aclk) begin
        fraction_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.num = m_tdata[63:0];
            got.den = m_tdata[127:64];
            got.is_equal = m_tdata[128];
            got.can_reduce = m_tdata[129];
            got.status = status_t'(m_tdata[131:130]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.num !== want.num) begin
                    $display("%0t: result_num expected %0d actual %0d",
                             $time, want.num, got.num);
                    mismatch_count++;
                end
                if (got.den !== want.den) begin
                    $display("%0t: result_den expected %0d actual %0d",
                             $time, want.den, got.den);
                    mismatch_count++;
                end
                if (got.is_equal !== want.is_equal) begin
                    $display("%0t: is_equal expected %0b actual %0b",
                             $time, want.is_equal, got.is_equal);
                    mismatch_count++;
                end
                if (got.can_reduce !== want.can_reduce) begin
                    $display("%0t: can_reduce expected %0b actual %0b",
                             $time, want.can_reduce, got.can_reduce);
                    mismatch_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // Receiver back-pressure, with stretches of constant readiness.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 7) == 0) begin
                m_tready = 1'b1;
                repeat ($urandom_range(20, 200)) @(negedge aclk);
            end
            stall = random_gap();
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    task automatic send_request(request_t req);
        int gap;
        gap = random_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {5'b0, req.den_b, req.num_b, req.den_a, req.num_a, req.kind};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_fraction(req));
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] random_operand();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            return $signed($urandom_range(0, 120)) - 60;
        end else if (pick < 50) begin
            case ($urandom_range(0, 4))
                0: return 0;
                1: return 1;
                2: return -1;
                3: return OP_MIN;
                default: return OP_MAX;
            endcase
        end else if (pick < 70) begin
            return $signed($urandom_range(0, 20000)) - 10000;
        end
        return $urandom();
    endfunction

    task automatic send_fraction(logic [2:0] kind, logic signed [31:0] na,
                                 logic signed [31:0] da, logic signed [31:0] nb,
                                 logic signed [31:0] db);
        request_t req;
        req.kind = kind;
        req.num_a = na;
        req.den_a = da;
        req.num_b = nb;
        req.den_b = db;
        send_request(req);
    endtask

    task automatic test_extremes();
        send_fraction(KIND_ADD, OP_MAX, OP_MAX, OP_MAX, OP_MAX - 1);
        send_fraction(KIND_ADD, OP_MIN, OP_MAX, OP_MIN, OP_MAX - 1);
        send_fraction(KIND_ADD, OP_MIN, OP_MIN, OP_MAX, OP_MIN);
        send_fraction(KIND_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
        send_fraction(KIND_MUL, OP_MAX, -1, OP_MIN, 1);
        send_fraction(KIND_DIV, OP_MIN, OP_MAX, OP_MAX, OP_MIN);
        send_fraction(KIND_EQ, OP_MIN, OP_MIN, OP_MAX, OP_MAX);
        send_fraction(KIND_RED, OP_MIN, OP_MIN, 0, 0);
        send_fraction(KIND_RED, OP_MIN, -1, 0, 0);
        send_fraction(KIND_RED, OP_MAX, OP_MAX, 0, 0);
    endtask

    task automatic test_special_cases();
        send_fraction(KIND_ADD, 1, 0, 1, 2);
        send_fraction(KIND_MUL, 1, 2, 1, 0);
        send_fraction(KIND_DIV, 3, 4, 0, 5);
        send_fraction(KIND_EQ, 3, 0, 3, 0);
        send_fraction(KIND_RED, 7, 0, 1, 1);
        send_fraction(KIND_EQ, 2, 4, -3, -6);
        send_fraction(KIND_EQ, 2, 4, 3, 5);
        send_fraction(KIND_RED, 12, -18, 0, 0);
        send_fraction(KIND_RED, 0, 5, 0, 0);
        send_fraction(KIND_ADD, 1, 6, 1, -4);
        send_fraction(KIND_RED, 5, 7, 0, 0);
        send_fraction(3'($urandom_range(int'(KIND_RED) + 1, 7)), -1, -1, -1, -1);
        send_fraction(3'd7, OP_MIN, OP_MAX, OP_MIN, OP_MAX);
    endtask

    task automatic test_random_mix();
        logic [2:0] kind;
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                kind = 3'($urandom_range(int'(KIND_RED) + 1, 7));
            end else begin
                kind = 3'($urandom_range(int'(KIND_ADD), int'(KIND_RED)));
            end
            send_fraction(kind, random_operand(), random_operand(),
                          random_operand(), random_operand());
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_extremes();
        test_special_cases();
        test_random_mix();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
